/* design/segtr_pkg.sv */
// Shared types, codes and helper functions of the segment tree range reducer.
package segtr_pkg;

  localparam int unsigned LEAVES_DEF = 1024;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned DATA_W     = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COMBINE_OP = 1'b0,
    CFG_FILL_VALUE = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_MUL = 3'd1,
    OP_MIN = 3'd2,
    OP_MAX = 3'd3,
    OP_AND = 3'd4,
    OP_OR  = 3'd5,
    OP_XOR = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    CMD_SET   = 2'd0,
    CMD_GET   = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    B_SWEEP,
    B_IDLE,
    B_SET_WR,
    B_SET_CMB,
    B_GET_WAIT,
    B_Q_INIT,
    B_Q_STEP,
    B_Q_CMB,
    B_DELIVER
  } back_state_e;

  function automatic int unsigned span_of(input int unsigned leaves);
    int unsigned s;
    s = 1;
    while (s < leaves) s = s * 2;
    return s;
  endfunction

  function automatic int unsigned node_w_of(input int unsigned leaves);
    return $clog2(2 * span_of(leaves)) + 1;
  endfunction

endpackage

/* design/segtr_if.sv */
// Handshake channels for items, results and register writes.
interface segtr_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [9:0]         leaf_index;
  logic signed [31:0] leaf_value;
  logic [10:0]        range_low;
  logic [10:0]        range_high;
  modport source(output valid, command, leaf_index, leaf_value, range_low, range_high,
                 input ready);
  modport sink(input valid, command, leaf_index, leaf_value, range_low, range_high,
               output ready);
endinterface

interface segtr_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  modport source(output valid, result_value, input ready);
  modport sink(input valid, result_value, output ready);
endinterface

interface segtr_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* design/segtr_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module segtr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

/* design/segtr_front.sv */
// Front end: accepts items, clamps ranges and maps leaves to tree nodes.
module segtr_front #(
  parameter int unsigned LEAVES = segtr_pkg::LEAVES_DEF,
  parameter int unsigned ENT_W  = 2 + 3 * segtr_pkg::node_w_of(LEAVES) + 32
) (
  segtr_in_if.sink          in_i,
  input  logic              init_busy_i,
  input  logic              q_full_i,
  output logic              push_valid_o,
  output logic [ENT_W-1:0]  push_data_o
);
  import segtr_pkg::*;

  localparam int unsigned SPAN = span_of(LEAVES);
  localparam int unsigned NW   = node_w_of(LEAVES);

  logic          leaf_ok;
  logic [NW-1:0] node;
  logic [NW-1:0] lo_c;
  logic [NW-1:0] hi_c;
  logic [NW-1:0] lo_n;
  logic [NW-1:0] hi_n;
  cmd_e          cmd;

  assign in_i.ready = !init_busy_i && !q_full_i;
  assign cmd        = cmd_e'(in_i.command);
  assign leaf_ok    = 32'(in_i.leaf_index) < 32'(LEAVES);
  assign node       = leaf_ok ? NW'(in_i.leaf_index) + NW'(SPAN) : '0;

  always_comb begin
    lo_c = (32'(in_i.range_low) > 32'(LEAVES)) ? NW'(LEAVES) : NW'(in_i.range_low);
    hi_c = (32'(in_i.range_high) > 32'(LEAVES)) ? NW'(LEAVES) : NW'(in_i.range_high);
    if (lo_c < hi_c) begin
      lo_n = lo_c + NW'(SPAN);
      hi_n = hi_c + NW'(SPAN);
    end else begin
      lo_n = '0;
      hi_n = '0;
    end
  end

  // A set of a leaf beyond the tree is accepted and dropped.
  assign push_valid_o = in_i.valid && in_i.ready && !(cmd == CMD_SET && !leaf_ok);
  assign push_data_o  = {in_i.command, node, lo_n, hi_n, in_i.leaf_value};
endmodule

/* design/segtr_queue.sv */
// Two-entry queue of classified items between the front and back ends.
module segtr_queue #(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  output logic             pop_valid_o,
  output logic [WIDTH-1:0] pop_data_o,
  input  logic             pop_ready_i
);
  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             pop;

  assign pop         = pop_valid_o && pop_ready_i;
  assign full_o      = cnt_q == 2'd2;
  assign pop_valid_o = cnt_q != 2'd0;
  assign pop_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_valid_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push_valid_i) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_valid_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end
endmodule

/* design/segtr_back.sv */
// Back end: walks the tree in memory for sets, gets, queries and rebuilds.
module segtr_back #(
  parameter int unsigned LEAVES = segtr_pkg::LEAVES_DEF,
  parameter int unsigned ENT_W  = 2 + 3 * segtr_pkg::node_w_of(LEAVES) + 32,
  parameter int unsigned AW     = $clog2(2 * segtr_pkg::span_of(LEAVES))
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  input  logic [ENT_W-1:0] pop_data_i,
  output logic             pop_ready_o,
  input  logic [2:0]       combine_op_i,
  input  logic [31:0]      fill_value_i,
  output logic             init_busy_o,
  output logic             ram_we_o,
  output logic [AW-1:0]    ram_waddr_o,
  output logic [31:0]      ram_wdata_o,
  output logic [AW-1:0]    ram_raddr_o,
  input  logic [31:0]      ram_rdata_i,
  segtr_out_if.source      out_o
);
  import segtr_pkg::*;

  localparam int unsigned NW = node_w_of(LEAVES);

  function automatic logic [31:0] apply_op(input logic [2:0] op, input logic [31:0] a,
                                           input logic [31:0] b);
    logic [31:0] p;
    p = a * b;
    case (op)
      OP_MUL:  return p;
      OP_MIN:  return ($signed(a) < $signed(b)) ? a : b;
      OP_MAX:  return ($signed(a) > $signed(b)) ? a : b;
      OP_AND:  return a & b;
      OP_OR:   return a | b;
      OP_XOR:  return a ^ b;
      default: return a + b;
    endcase
  endfunction

  back_state_e   state_q, state_d;
  logic [31:0]   acc_q, acc_d;
  logic [NW-1:0] node_q, node_d;
  logic [NW-1:0] lo_q, lo_d;
  logic [NW-1:0] hi_q, hi_d;
  logic [AW-1:0] k_q, k_d;
  logic [31:0]   lvl_q, lvl_d;
  logic [31:0]   fill_cap_q, fill_cap_d;
  logic [2:0]    op_cap_q, op_cap_d;
  logic          init_q, init_d;
  logic          out_valid_q, out_valid_d;
  logic [31:0]   out_data_q, out_data_d;

  cmd_e          ent_cmd;
  logic [NW-1:0] ent_node;
  logic [NW-1:0] ent_lo;
  logic [NW-1:0] ent_hi;
  logic [31:0]   ent_value;
  logic [NW-1:0] sib;
  logic [NW-1:0] hm1;
  logic [2:0]    alu_op;
  logic [31:0]   alu_a;
  logic [31:0]   alu_b;
  logic [31:0]   alu_y;

  assign ent_value = pop_data_i[31:0];
  assign ent_hi    = pop_data_i[NW+31:32];
  assign ent_lo    = pop_data_i[2*NW+31:NW+32];
  assign ent_node  = pop_data_i[3*NW+31:2*NW+32];
  assign ent_cmd   = cmd_e'(pop_data_i[ENT_W-1 -: 2]);
  assign sib       = node_q ^ NW'(1);
  assign hm1       = hi_q - NW'(1);
  assign alu_y     = apply_op(alu_op, alu_a, alu_b);

  assign init_busy_o        = init_q;
  assign out_o.valid        = out_valid_q;
  assign out_o.result_value = out_data_q;

  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    node_d      = node_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    k_d         = k_q;
    lvl_d       = lvl_q;
    fill_cap_d  = fill_cap_q;
    op_cap_d    = op_cap_q;
    init_d      = init_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;
    pop_ready_o = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = node_q[AW-1:0];
    ram_wdata_o = acc_q;
    ram_raddr_o = ent_node[AW-1:0];
    alu_op      = combine_op_i;
    alu_a       = acc_q;
    alu_b       = ram_rdata_i;
    unique case (state_q)
      B_SWEEP: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = k_q;
        ram_wdata_o = (k_q == '0) ? fill_cap_q : lvl_q;
        alu_op      = op_cap_q;
        alu_a       = lvl_q;
        alu_b       = lvl_q;
        if (k_q == '0) begin
          init_d  = 1'b0;
          state_d = B_IDLE;
        end else begin
          k_d = k_q - AW'(1);
          // The first node of each level going down starts the next level up.
          if ((k_q & (k_q - AW'(1))) == '0) begin
            lvl_d = alu_y;
          end
        end
      end
      B_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          case (ent_cmd)
            CMD_SET: begin
              acc_d   = ent_value;
              node_d  = ent_node;
              state_d = B_SET_WR;
            end
            CMD_GET: begin
              state_d = B_GET_WAIT;
            end
            CMD_QUERY: begin
              ram_raddr_o = '0;
              lo_d        = ent_lo;
              hi_d        = ent_hi;
              state_d     = B_Q_INIT;
            end
            default: begin
              lvl_d      = fill_value_i;
              fill_cap_d = fill_value_i;
              op_cap_d   = combine_op_i;
              k_d        = '1;
              state_d    = B_SWEEP;
            end
          endcase
        end
      end
      B_SET_WR: begin
        ram_we_o = 1'b1;
        if (node_q == NW'(1)) begin
          state_d = B_IDLE;
        end else begin
          ram_raddr_o = sib[AW-1:0];
          state_d     = B_SET_CMB;
        end
      end
      B_SET_CMB: begin
        acc_d   = alu_y;
        node_d  = node_q >> 1;
        state_d = B_SET_WR;
      end
      B_GET_WAIT: begin
        acc_d   = ram_rdata_i;
        state_d = B_DELIVER;
      end
      B_Q_INIT: begin
        acc_d   = ram_rdata_i;
        state_d = B_Q_STEP;
      end
      B_Q_STEP: begin
        if (lo_q < hi_q) begin
          if (lo_q[0]) begin
            ram_raddr_o = lo_q[AW-1:0];
            lo_d        = lo_q + NW'(1);
            state_d     = B_Q_CMB;
          end else if (hi_q[0]) begin
            ram_raddr_o = hm1[AW-1:0];
            hi_d        = hm1;
            state_d     = B_Q_CMB;
          end else begin
            lo_d = lo_q >> 1;
            hi_d = hi_q >> 1;
          end
        end else begin
          state_d = B_DELIVER;
        end
      end
      B_Q_CMB: begin
        acc_d   = alu_y;
        state_d = B_Q_STEP;
      end
      B_DELIVER: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_data_d  = acc_q;
          state_d     = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_SWEEP;
      k_q         <= '1;
      lvl_q       <= '0;
      fill_cap_q  <= '0;
      op_cap_q    <= OP_ADD;
      init_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      lvl_q       <= lvl_d;
      fill_cap_q  <= fill_cap_d;
      op_cap_q    <= op_cap_d;
      init_q      <= init_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    node_q     <= node_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    out_data_q <= out_data_d;
  end
endmodule

/* design/segment_tree_range_reduce_core.sv */
// Segment tree range reducer: front end, item queue, back end and node memory.
// A set writes the leaf and each node on its path to the root, with one combine per level below the root.
// A get reads one node; a query combines the nodes that cover its range.
// Items are carried out one at a time; the back end takes no new item until it is through with the last.
// After reset, and on each clear, a pass rewrites every node;
// no item is accepted during the pass that follows reset.
module segment_tree_range_reduce_core #(
  parameter int unsigned LEAVES = segtr_pkg::LEAVES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  segtr_in_if.sink    in_i,
  segtr_out_if.source out_o,
  segtr_cfg_if.sink   cfg_i
);
  import segtr_pkg::*;

  localparam int unsigned SPAN  = span_of(LEAVES);
  localparam int unsigned AW    = $clog2(2 * SPAN);
  localparam int unsigned ENT_W = 2 + 3 * node_w_of(LEAVES) + 32;

  logic [2:0]       combine_op_q;
  logic [31:0]      fill_value_q;
  logic             init_busy;
  logic             q_full;
  logic             push_valid;
  logic [ENT_W-1:0] push_data;
  logic             pop_valid;
  logic             pop_ready;
  logic [ENT_W-1:0] pop_data;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [31:0]      ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [31:0]      ram_rdata;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      combine_op_q <= OP_ADD;
      fill_value_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_COMBINE_OP: combine_op_q <= cfg_i.data[2:0];
        CFG_FILL_VALUE: fill_value_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  segtr_front #(.LEAVES(LEAVES), .ENT_W(ENT_W)) u_front (
    .in_i        (in_i),
    .init_busy_i (init_busy),
    .q_full_i    (q_full),
    .push_valid_o(push_valid),
    .push_data_o (push_data)
  );

  segtr_queue #(.WIDTH(ENT_W)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_valid_o (pop_valid),
    .pop_data_o  (pop_data),
    .pop_ready_i (pop_ready)
  );

  segtr_back #(.LEAVES(LEAVES), .ENT_W(ENT_W), .AW(AW)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_data_i  (pop_data),
    .pop_ready_o (pop_ready),
    .combine_op_i(combine_op_q),
    .fill_value_i(fill_value_q),
    .init_busy_o (init_busy),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .out_o       (out_o)
  );

  segtr_ram #(.WIDTH(32), .DEPTH(2 * SPAN)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );
endmodule
